// ----- hdl/wpm_pkg.sv -----
package wpm_pkg;

    localparam int MAX_OPS_DEFAULT = 8;

    localparam int ETA_WIDTH    = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int W_WIDTH      = 24;
    localparam int PROD_WIDTH   = 2 * W_WIDTH;
    localparam int SUM_WIDTH    = 64;
    localparam int SQ_WIDTH     = 2 * ETA_WIDTH;
    localparam int SCALED_WIDTH = 56;
    localparam int WEIGHT_SHIFT = 30;

    localparam logic [W_WIDTH-1:0] SCALE_WEIGHT = 24'd10000000;
    localparam logic [W_WIDTH-1:0] WEIGHT_MAX   = 24'hFFFFFF;

    // Cycles between the last word of a point and the start of the reduction pass.
    localparam int FLUSH_CYCLES = 8;
    localparam int FLUSH_CNT_W  = $clog2(FLUSH_CYCLES);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_FLUSH,
        ST_REDUCE,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    // A new entry travelling down the row of cells.
    typedef struct packed {
        logic                   valid;
        logic                   stored;
        logic [W_WIDTH-1:0]     w;
        logic [ANGLE_WIDTH-1:0] phi;
        logic                   wsat;
    } token_t;

    // The reduction pass that collects the per-cell partial sums.
    typedef struct packed {
        logic                 valid;
        logic [SUM_WIDTH-1:0] wsum;
        logic [SUM_WIDTH-1:0] dsum;
        logic                 sat;
    } red_t;

    typedef struct packed {
        logic                   valid;
        logic [ANGLE_WIDTH-1:0] quotient;
        logic                   sat;
    } div_result_t;

    // Saturating add; the top bit reports that the sum clamped.
    function automatic logic [SUM_WIDTH:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                   input logic [SUM_WIDTH-1:0] b);
        logic [SUM_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[SUM_WIDTH])
        begin
            s = {1'b1, {SUM_WIDTH{1'b1}}};
        end
        return s;
    endfunction

endpackage

// ----- hdl/wpm_item_if.sv -----
interface wpm_item_if;
    import wpm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   active;
    logic [ETA_WIDTH-1:0]   eta;
    logic [ANGLE_WIDTH-1:0] phi_one;
    logic                   last;

    modport source (output valid, active, eta, phi_one, last, input ready);
    modport sink   (input valid, active, eta, phi_one, last, output ready);
endinterface

// ----- hdl/wpm_result_if.sv -----
interface wpm_result_if;
    import wpm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ANGLE_WIDTH-1:0] mis_angle;
    logic                   saturated;

    modport source (output valid, mis_angle, saturated, input ready);
    modport sink   (input valid, mis_angle, saturated, output ready);
endinterface

// ----- hdl/wpm_weight.sv -----
module wpm_weight (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic [wpm_pkg::ETA_WIDTH-1:0]   eta,
    input  logic [wpm_pkg::ANGLE_WIDTH-1:0] phi_one,
    output wpm_pkg::token_t                 tok
);
    import wpm_pkg::*;

    logic                    v1_reg, v2_reg, v3_reg;
    logic [SQ_WIDTH-1:0]     sq_reg;
    logic [SCALED_WIDTH-1:0] scaled_reg;
    logic [ANGLE_WIDTH-1:0]  phi1_reg, phi2_reg, phi3_reg;
    logic [W_WIDTH-1:0]      w_reg;
    logic                    wsat_reg;

    logic [SCALED_WIDTH:0]                 rounded;
    logic [SCALED_WIDTH-WEIGHT_SHIFT:0]    shifted;
    logic [SCALED_WIDTH-WEIGHT_SHIFT+1:0]  w_plus;
    logic                                  w_over;

    always_comb
    begin
        rounded = {1'b0, scaled_reg} + ((SCALED_WIDTH + 1)'(1) << (WEIGHT_SHIFT - 1));
        shifted = rounded[SCALED_WIDTH:WEIGHT_SHIFT];
        w_plus  = {1'b0, shifted} + (SCALED_WIDTH - WEIGHT_SHIFT + 2)'(1);
        w_over  = w_plus > (SCALED_WIDTH - WEIGHT_SHIFT + 2)'(WEIGHT_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg     <= SQ_WIDTH'(eta) * SQ_WIDTH'(eta);
        phi1_reg   <= phi_one;
        scaled_reg <= SCALED_WIDTH'(sq_reg) * SCALED_WIDTH'(SCALE_WEIGHT);
        phi2_reg   <= phi1_reg;
        w_reg      <= w_over ? WEIGHT_MAX : w_plus[W_WIDTH-1:0];
        wsat_reg   <= w_over;
        phi3_reg   <= phi2_reg;
    end

    assign tok.valid  = v3_reg;
    assign tok.stored = 1'b0;
    assign tok.w      = w_reg;
    assign tok.phi    = phi3_reg;
    assign tok.wsat   = wsat_reg;

endmodule

// ----- hdl/wpm_cell.sv -----
module wpm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  wpm_pkg::token_t tok_in,
    output wpm_pkg::token_t tok_out,
    input  wpm_pkg::red_t   red_in,
    output wpm_pkg::red_t   red_out
);
    import wpm_pkg::*;

    logic                   ent_valid_reg, ent_valid_next;
    logic [W_WIDTH-1:0]     ent_w_reg;
    logic [ANGLE_WIDTH-1:0] ent_a_reg;

    logic                   pa_valid_reg;
    logic [PROD_WIDTH-1:0]  p_reg;
    logic [ANGLE_WIDTH-1:0] d_reg;
    logic                   pb_valid_reg;
    logic [PROD_WIDTH-1:0]  p2_reg;
    logic [SUM_WIDTH-1:0]   pd_reg;

    logic [SUM_WIDTH-1:0]   acc_w_reg, acc_w_next;
    logic [SUM_WIDTH-1:0]   acc_d_reg, acc_d_next;
    logic                   sat_reg, sat_next;

    logic                   tok_valid_reg, tok_stored_reg, tok_wsat_reg;
    logic [W_WIDTH-1:0]     tok_w_reg;
    logic [ANGLE_WIDTH-1:0] tok_phi_reg;

    logic                   red_valid_reg, red_sat_reg;
    logic [SUM_WIDTH-1:0]   red_w_reg, red_d_reg;

    logic                   pair_here, store_here;
    logic [ANGLE_WIDTH-1:0] diff;
    logic                   ovf_w, ovf_d, rovf_w, rovf_d;
    logic [SUM_WIDTH-1:0]   red_w_next, red_d_next;

    // Cells fill in order, so the first empty cell a fresh entry meets is its slot.
    assign pair_here  = tok_in.valid && ent_valid_reg;
    assign store_here = tok_in.valid && !tok_in.stored && !ent_valid_reg;
    assign diff       = (tok_in.phi >= ent_a_reg) ? tok_in.phi - ent_a_reg
                                                  : ent_a_reg - tok_in.phi;

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        acc_w_next     = acc_w_reg;
        acc_d_next     = acc_d_reg;
        sat_next       = sat_reg;
        ovf_w          = 1'b0;
        ovf_d          = 1'b0;

        {rovf_w, red_w_next} = sat_add(red_in.wsum, acc_w_reg);
        {rovf_d, red_d_next} = sat_add(red_in.dsum, acc_d_reg);

        if (pb_valid_reg)
        begin
            {ovf_w, acc_w_next} = sat_add(acc_w_reg, SUM_WIDTH'(p2_reg));
            {ovf_d, acc_d_next} = sat_add(acc_d_reg, pd_reg);
            sat_next = sat_next | ovf_w | ovf_d;
        end
        if (store_here)
        begin
            ent_valid_next = 1'b1;
            sat_next       = sat_next | tok_in.wsat;
        end
        // The reduction pass takes this cell's share of the point and clears it.
        if (red_in.valid)
        begin
            ent_valid_next = 1'b0;
            acc_w_next     = '0;
            acc_d_next     = '0;
            sat_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg  <= 1'b0;
            pa_valid_reg   <= 1'b0;
            pb_valid_reg   <= 1'b0;
            acc_w_reg      <= '0;
            acc_d_reg      <= '0;
            sat_reg        <= 1'b0;
            tok_valid_reg  <= 1'b0;
            tok_stored_reg <= 1'b0;
            red_valid_reg  <= 1'b0;
        end
        else
        begin
            ent_valid_reg  <= ent_valid_next;
            pa_valid_reg   <= pair_here;
            pb_valid_reg   <= pa_valid_reg;
            acc_w_reg      <= acc_w_next;
            acc_d_reg      <= acc_d_next;
            sat_reg        <= sat_next;
            tok_valid_reg  <= tok_in.valid;
            tok_stored_reg <= tok_in.stored | store_here;
            red_valid_reg  <= red_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_here)
        begin
            ent_w_reg <= tok_in.w;
            ent_a_reg <= tok_in.phi;
        end
        p_reg        <= PROD_WIDTH'(tok_in.w) * PROD_WIDTH'(ent_w_reg);
        d_reg        <= diff;
        p2_reg       <= p_reg;
        pd_reg       <= SUM_WIDTH'(p_reg) * SUM_WIDTH'(d_reg);
        tok_w_reg    <= tok_in.w;
        tok_phi_reg  <= tok_in.phi;
        tok_wsat_reg <= tok_in.wsat;
        red_w_reg    <= red_w_next;
        red_d_reg    <= red_d_next;
        red_sat_reg  <= red_in.sat | sat_reg | rovf_w | rovf_d;
    end

    assign tok_out.valid  = tok_valid_reg;
    assign tok_out.stored = tok_stored_reg;
    assign tok_out.w      = tok_w_reg;
    assign tok_out.phi    = tok_phi_reg;
    assign tok_out.wsat   = tok_wsat_reg;

    assign red_out.valid  = red_valid_reg;
    assign red_out.wsum   = red_w_reg;
    assign red_out.dsum   = red_d_reg;
    assign red_out.sat    = red_sat_reg;

    // The reduction must trail every product still in this cell's pipeline.
    a_red_after_products: assert property (@(posedge clk) disable iff (!rst_n)
        red_in.valid |-> !tok_in.valid && !pa_valid_reg && !pb_valid_reg)
        else $error("reduction overtook a pending product");

    a_store_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        store_here |=> ent_valid_reg && !pa_valid_reg)
        else $error("entry store collided with a pairing");

endmodule

// ----- hdl/wpm_divider.sv -----
module wpm_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wpm_pkg::SUM_WIDTH-1:0] num,
    input  logic [wpm_pkg::SUM_WIDTH-1:0] den,
    output wpm_pkg::div_result_t          res
);
    import wpm_pkg::*;

    localparam int CNT_W = $clog2(SUM_WIDTH);

    logic                 run_reg, fin_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_WIDTH-1:0] rem_reg, quo_reg, den_reg;

    logic [SUM_WIDTH:0]   shifted, trial;
    logic                 ge;
    logic                 round_up, hi_bits;
    logic                 last_step;

    assign shifted   = {rem_reg, quo_reg[SUM_WIDTH-1]};
    assign ge        = shifted >= {1'b0, den_reg};
    assign trial     = shifted - {1'b0, den_reg};
    assign last_step = run_reg && (cnt_reg == CNT_W'(SUM_WIDTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            fin_reg <= last_step;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? trial[SUM_WIDTH-1:0] : shifted[SUM_WIDTH-1:0];
            quo_reg <= {quo_reg[SUM_WIDTH-2:0], ge};
        end
    end

    // Round half up: the remainder counts as a half when twice it reaches the divisor.
    always_comb
    begin
        round_up     = {rem_reg, 1'b0} >= {1'b0, den_reg};
        hi_bits      = |quo_reg[SUM_WIDTH-1:ANGLE_WIDTH];
        res.valid    = fin_reg;
        res.sat      = hi_bits || ((&quo_reg[ANGLE_WIDTH-1:0]) && round_up);
        res.quotient = res.sat ? {ANGLE_WIDTH{1'b1}}
                               : quo_reg[ANGLE_WIDTH-1:0] + ANGLE_WIDTH'(round_up);
    end

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg && !fin_reg)
        else $error("divider started while busy");

endmodule

// ----- hdl/weighted_pair_misorientation_core.sv -----
// Weighted mean misorientation of one material point. Words of a point are taken one
// per cycle; each active word gets its weight in a three-stage front end and then walks
// down a row of MAX_OPS cells, pairing with the entry each cell holds and settling into
// the first empty one. After the word marked last the block stops taking words while it
// flushes the cell pipelines, runs a reduction pass that gathers the partial sums from
// the cells, divides in a bit-serial divider with combinational rounding, and loads the
// output register; a point with no pair skips the divider. A result waits in the output
// register while the next point is taken in, and the block waits longer when that
// register is still full.
module weighted_pair_misorientation_core #(
    parameter int MAX_OPS = wpm_pkg::MAX_OPS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    wpm_item_if.sink      item,
    wpm_result_if.source  result
);
    import wpm_pkg::*;

    state_t                 state_reg, state_next;
    logic [FLUSH_CNT_W-1:0] flush_cnt_reg, flush_cnt_next;
    logic                   red_start_reg, red_start_next;
    logic                   drop_reg, drop_next;
    logic [ANGLE_WIDTH-1:0] res_q_reg, res_q_next;
    logic                   res_sat_reg, res_sat_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ANGLE_WIDTH-1:0] out_q_reg, out_q_next;
    logic                   out_sat_reg, out_sat_next;
    logic                   div_start;
    logic                   take;

    token_t      tok [MAX_OPS+1];
    red_t        red [MAX_OPS+1];
    div_result_t div_res;

    assign take = item.valid && item.ready && item.active;

    wpm_weight u_weight (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .eta     (item.eta),
        .phi_one (item.phi_one),
        .tok     (tok[0])
    );

    assign red[0].valid = red_start_reg;
    assign red[0].wsum  = '0;
    assign red[0].dsum  = '0;
    assign red[0].sat   = 1'b0;

    for (genvar k = 0; k < MAX_OPS; k++)
    begin : g_cell
        wpm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1]),
            .red_in  (red[k]),
            .red_out (red[k+1])
        );
    end

    wpm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (red[MAX_OPS].dsum),
        .den   (red[MAX_OPS].wsum),
        .res   (div_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        flush_cnt_next = flush_cnt_reg;
        red_start_next = 1'b0;
        drop_next      = drop_reg;
        res_q_next     = res_q_reg;
        res_sat_next   = res_sat_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_q_next     = out_q_reg;
        out_sat_next   = out_sat_reg;
        div_start      = 1'b0;
        item.ready     = (state_reg == ST_RUN);

        // A word that leaves the last cell unstored found the row full.
        if (tok[MAX_OPS].valid && !tok[MAX_OPS].stored)
        begin
            drop_next = 1'b1;
        end

        case (state_reg)
            ST_RUN:
            begin
                if (item.valid && item.last)
                begin
                    state_next     = ST_FLUSH;
                    flush_cnt_next = FLUSH_CNT_W'(FLUSH_CYCLES - 1);
                end
            end
            ST_FLUSH:
            begin
                if (flush_cnt_reg == '0)
                begin
                    state_next     = ST_REDUCE;
                    red_start_next = 1'b1;
                end
                else
                begin
                    flush_cnt_next = flush_cnt_reg - FLUSH_CNT_W'(1);
                end
            end
            ST_REDUCE:
            begin
                if (red[MAX_OPS].valid)
                begin
                    drop_next    = 1'b0;
                    res_q_next   = '0;
                    res_sat_next = red[MAX_OPS].sat | drop_reg;
                    // With no pair the weight sum stays zero and the result is zero.
                    if (red[MAX_OPS].wsum == '0)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_DIVIDE;
                        div_start  = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_res.valid)
                begin
                    state_next   = ST_HOLD;
                    res_q_next   = div_res.quotient;
                    res_sat_next = res_sat_reg | div_res.sat;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next     = ST_RUN;
                    out_valid_next = 1'b1;
                    out_q_next     = res_q_reg;
                    out_sat_next   = res_sat_reg;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            flush_cnt_reg <= '0;
            red_start_reg <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_cnt_reg <= flush_cnt_next;
            red_start_reg <= red_start_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_q_reg   <= res_q_next;
        res_sat_reg <= res_sat_next;
        out_q_reg   <= out_q_next;
        out_sat_reg <= out_sat_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.mis_angle = out_q_reg;
    assign result.saturated = out_sat_reg;

    a_reduce_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        red[MAX_OPS].valid |-> state_reg == ST_REDUCE)
        else $error("reduction finished outside the reduce phase");

    a_divide_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.valid |-> state_reg == ST_DIVIDE)
        else $error("quotient arrived outside the divide phase");

endmodule

// ----- tb/weighted_pair_misorientation_core_test.sv -----
module weighted_pair_misorientation_core_test;
    import wpm_pkg::*;

    localparam int MAX_OPS     = MAX_OPS_DEFAULT;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = MAX_OPS + 100;
    localparam int RANDOM_WORDS = 2000;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] mis_angle;
        logic                   saturated;
    } point_result_t;

    // Tracks the point being built and holds the results still owed by the block.
    class misorientation_board;
        logic [W_WIDTH-1:0]     held_weight [MAX_OPS];
        logic [ANGLE_WIDTH-1:0] held_angle  [MAX_OPS];
        int unsigned            held_count;
        logic [SUM_WIDTH-1:0]   pair_weight_sum;
        logic [SUM_WIDTH-1:0]   pair_diff_sum;
        bit                     clamped;
        point_result_t          expected_points[$];
        int unsigned            failures;

        function new();
            failures = 0;
            clear_point();
        endfunction

        function void clear_point();
            held_count      = 0;
            pair_weight_sum = '0;
            pair_diff_sum   = '0;
            clamped         = 1'b0;
        endfunction

        function logic [SUM_WIDTH-1:0] add_clamped(input logic [SUM_WIDTH-1:0] a,
                                                   input logic [SUM_WIDTH-1:0] b);
            logic [SUM_WIDTH:0] total;
            total = {1'b0, a} + {1'b0, b};
            if (total[SUM_WIDTH])
            begin
                clamped = 1'b1;
                return '1;
            end
            return total[SUM_WIDTH-1:0];
        endfunction

        // Weight in units of 10^-7: round(10^7 * eta^2 / 2^30) + 1, clamped to 24 bits.
        function logic [W_WIDTH-1:0] weight_of(input logic [ETA_WIDTH-1:0] eta);
            logic [63:0] scaled;
            scaled = {48'd0, eta} * {48'd0, eta};
            scaled = scaled * 64'd10000000;
            scaled = ((scaled + 64'h2000_0000) >> 30) + 64'd1;
            if (scaled > 64'h00FF_FFFF)
            begin
                clamped = 1'b1;
                return '1;
            end
            return scaled[W_WIDTH-1:0];
        endfunction

        function void take_word(input logic act, input logic [ETA_WIDTH-1:0] eta,
                                input logic [ANGLE_WIDTH-1:0] phi, input logic fin);
            logic [W_WIDTH-1:0]     w;
            logic [PROD_WIDTH-1:0]  p;
            logic [ANGLE_WIDTH-1:0] d;
            logic [79:0]            pd;
            logic [SUM_WIDTH-1:0]   q;
            logic [SUM_WIDTH-1:0]   r;
            point_result_t          res;
            if (act)
            begin
                w = weight_of(eta);
                for (int k = 0; k < held_count; k++)
                begin
                    p = {24'd0, w} * {24'd0, held_weight[k]};
                    d = (phi >= held_angle[k]) ? phi - held_angle[k] : held_angle[k] - phi;
                    pair_weight_sum = add_clamped(pair_weight_sum, {16'd0, p});
                    pd = {32'd0, p} * {64'd0, d};
                    if (pd[79:64] != 16'd0)
                    begin
                        clamped = 1'b1;
                        pd[63:0] = '1;
                    end
                    pair_diff_sum = add_clamped(pair_diff_sum, pd[63:0]);
                end
                // A word that finds the store full still pairs, but is dropped.
                if (held_count < MAX_OPS)
                begin
                    held_weight[held_count] = w;
                    held_angle[held_count]  = phi;
                    held_count++;
                end
                else
                begin
                    clamped = 1'b1;
                end
            end
            if (fin)
            begin
                q = '0;
                if (held_count >= 2 && pair_weight_sum != '0)
                begin
                    q = pair_diff_sum / pair_weight_sum;
                    r = pair_diff_sum % pair_weight_sum;
                    if (r >= pair_weight_sum - r)
                        q++;
                    if (q > 64'hFFFF)
                    begin
                        clamped = 1'b1;
                        q = 64'hFFFF;
                    end
                end
                res.mis_angle = q[ANGLE_WIDTH-1:0];
                res.saturated = clamped;
                expected_points.insert(expected_points.size(), res);
                clear_point();
            end
        endfunction

        function void check_result(input logic [ANGLE_WIDTH-1:0] mis_angle,
                                   input logic saturated);
            point_result_t want;
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %0d saturated %0b",
                         $time, mis_angle, saturated);
                failures++;
                return;
            end
            want = expected_points.pop_front();
            if (mis_angle !== want.mis_angle)
            begin
                $display("%0t: mis_angle expected %0d actual %0d",
                         $time, want.mis_angle, mis_angle);
                failures++;
            end
            if (saturated !== want.saturated)
            begin
                $display("%0t: saturated expected %0b actual %0b",
                         $time, want.saturated, saturated);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wpm_item_if   item_bus();
    wpm_result_if result_bus();

    weighted_pair_misorientation_core #(
        .MAX_OPS (MAX_OPS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    misorientation_board board;
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;
    int unsigned         stall_cycles;
    int unsigned         counted_words;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Result side: check what was taken at this edge, then pick ready for the next one.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            board.check_result(result_bus.mis_angle, result_bus.saturated);
        result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [ETA_WIDTH-1:0] eta,
                             input logic [ANGLE_WIDTH-1:0] phi, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.active  <= act;
        item_bus.eta     <= eta;
        item_bus.phi_one <= phi;
        item_bus.last    <= fin;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        board.take_word(act, eta, phi, fin);
    endtask

    task automatic wait_for_results();
        item_bus.valid <= 1'b0;
        while (board.expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_directed();
        send_word(1'b0, 16'd0, 16'd0, 1'b1);
        send_word(1'b1, 16'd32768, 16'd46080, 1'b1);
        send_word(1'b1, 16'd0, 16'd0, 1'b0);
        send_word(1'b1, 16'd0, 16'd46080, 1'b1);
        // An eta well above 1.0 clamps the weight; the point closes on an idle entry.
        send_word(1'b1, 16'd32768, 16'd0, 1'b0);
        send_word(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_word(1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        // More active entries than the store holds.
        for (int k = 0; k < MAX_OPS + 2; k++)
            send_word(1'b1, 16'(k * 3000), 16'(k * 4608), k == MAX_OPS + 1);
        // Largest weights with the widest angle gap overflow the difference sum.
        send_word(1'b1, 16'hFFFF, 16'h0000, 1'b0);
        send_word(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_word(1'b1, 16'hFFFF, 16'h0000, 1'b1);
    endtask

    task automatic send_random_point();
        int unsigned            len;
        logic                   act;
        logic [ETA_WIDTH-1:0]   eta;
        logic [ANGLE_WIDTH-1:0] phi;
        logic                   fin;
        len = ($urandom_range(9) == 0) ? $urandom_range(MAX_OPS + 4, MAX_OPS) :
                                         $urandom_range(MAX_OPS, 1);
        for (int k = 0; k < len; k++)
        begin
            act = ($urandom_range(99) < 80);
            case ($urandom_range(9))
                0:       eta = 16'($urandom_range(65535));
                1:       eta = $urandom_range(1) ? 16'd32768 : 16'd0;
                default: eta = 16'($urandom_range(32768));
            endcase
            case ($urandom_range(9))
                0:       phi = 16'($urandom_range(65535));
                1:       phi = 16'($urandom_range(3) * 15360);
                default: phi = 16'($urandom_range(46080));
            endcase
            fin = (k == len - 1);
            send_word(act, eta, phi, fin);
            counted_words++;
        end
    endtask

    initial
    begin
        board            = new();
        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.active  = 1'b0;
        item_bus.eta     = '0;
        item_bus.phi_one = '0;
        item_bus.last    = 1'b0;
        result_bus.ready = 1'b0;
        send_idle_pct    = 34;
        recv_idle_pct    = 53;
        stall_cycles     = 0;
        counted_words    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        wait_for_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 53;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (counted_words < (phase + 1) * RANDOM_WORDS / 3)
                send_random_point();
            // Hold the sender off until every owed result is back.
            wait_for_results();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.failures == 0 && board.expected_points.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/wpm_pkg.sv
hdl/wpm_item_if.sv
hdl/wpm_result_if.sv
hdl/wpm_weight.sv
hdl/wpm_cell.sv
hdl/wpm_divider.sv
hdl/weighted_pair_misorientation_core.sv
tb/weighted_pair_misorientation_core_test.sv
